FILE: rtl/assert_macros.svh
// Assertion helpers, used by wred_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/wred_pkg.sv
// ----------------------------------------------------------------------------
// wred_pkg
// Types and constants shared by the WRED drop decision controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package wred_pkg;

  localparam int AVG_W     = 27;   // average, unsigned Q11.16
  localparam int THR_W     = 11;   // threshold registers
  localparam int Q16_W     = 16;   // wq, maxp, pb
  localparam int FAC_W     = 17;   // Q0.16 values that may reach 1.0
  localparam int MUL_A_W   = 27;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 50;
  localparam int CNT_W     = 7;
  localparam int PCT_W     = 7;
  localparam int TIME_W    = 32;
  localparam int QLEN_W    = 11;
  localparam int DEC_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_STEPS = 16;

  localparam logic [AVG_W-1:0] AVG_MAX     = {AVG_W{1'b1}};
  localparam logic [FAC_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_HALF  = 50'd32768;
  localparam logic signed [CNT_W-1:0] COUNT_LIMIT = 7'sd50;
  localparam logic [Q16_W-1:0] PCT_SCALE   = 16'd100;

  typedef enum logic [DEC_W-1:0] {
    DEC_BELOW_MIN  = 3'd0,
    DEC_RAND_KEEP  = 3'd1,
    DEC_RAND_DROP  = 3'd2,
    DEC_COUNT_DROP = 3'd3,
    DEC_ABOVE_MAX  = 3'd4,
    DEC_DRAINED    = 3'd5
  } dec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_0    = 3'd0,
    CFG_MAX_0    = 3'd1,
    CFG_MIN_1    = 3'd2,
    CFG_MAX_1    = 3'd3,
    CFG_WEIGHT   = 3'd4,
    CFG_MAX_PROB = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_BELOW   = 2'd0,
    REGION_BETWEEN = 2'd1,
    REGION_ABOVE   = 2'd2
  } region_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_POW_INIT,
    OP_POW_MP,
    OP_POW_UP,
    OP_POW_MB,
    OP_POW_UB,
    OP_DECAY_MUL,
    OP_ACC_LOAD,
    OP_EWMA_M2,
    OP_EWMA_A2,
    OP_EWMA_M1,
    OP_AVG_WR,
    OP_CLASSIFY,
    OP_PB_MUL,
    OP_DIV_INIT,
    OP_DIV,
    OP_CP_MUL,
    OP_CP_CHK,
    OP_RP_MUL,
    OP_RP_CHK,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POW_INIT,
    ST_POW_CHK,
    ST_POW_MP,
    ST_POW_UP,
    ST_POW_MB,
    ST_POW_UB,
    ST_DECAY_MUL,
    ST_DECAY_ACC,
    ST_EWMA_M1,
    ST_EWMA_A1,
    ST_EWMA_M2,
    ST_EWMA_A2,
    ST_AVG_WR,
    ST_CLASSIFY,
    ST_PB_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_CP_MUL,
    ST_CP_CHK,
    ST_RP_MUL,
    ST_RP_CHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    in_drain;
    logic    occ_zero;
    logic    exp_zero;
    logic    exp_bit0;
    region_t region;
    logic    div_last;
    logic    cp_final;
  } dp_status_t;

endpackage

FILE: rtl/wred_ctrl.sv
// ----------------------------------------------------------------------------
// wred_ctrl
// Sequencer for one item: drain, or idle decay or EWMA, classification, drop
// probability division and final commit; owns the handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wred_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output wred_pkg::dp_op_t    op,
  input  wred_pkg::dp_status_t stat
);
  import wred_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op             = OP_NONE;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat.in_drain) state_next = ST_FINISH;
        else if (stat.occ_zero)     state_next = ST_POW_INIT;
        else                        state_next = ST_EWMA_M1;
      end
      ST_POW_INIT: begin
        op         = OP_POW_INIT;
        state_next = ST_POW_CHK;
      end
      ST_POW_CHK: begin
        priority if (stat.exp_zero) state_next = ST_DECAY_MUL;
        else if (stat.exp_bit0)     state_next = ST_POW_MP;
        else                        state_next = ST_POW_MB;
      end
      ST_POW_MP: begin
        op         = OP_POW_MP;
        state_next = ST_POW_UP;
      end
      ST_POW_UP: begin
        op         = OP_POW_UP;
        state_next = ST_POW_MB;
      end
      ST_POW_MB: begin
        op         = OP_POW_MB;
        state_next = ST_POW_UB;
      end
      ST_POW_UB: begin
        op         = OP_POW_UB;
        state_next = ST_POW_CHK;
      end
      ST_DECAY_MUL: begin
        op         = OP_DECAY_MUL;
        state_next = ST_DECAY_ACC;
      end
      ST_DECAY_ACC: begin
        op         = OP_ACC_LOAD;
        state_next = ST_AVG_WR;
      end
      ST_EWMA_M1: begin
        op         = OP_EWMA_M1;
        state_next = ST_EWMA_A1;
      end
      ST_EWMA_A1: begin
        op         = OP_ACC_LOAD;
        state_next = ST_EWMA_M2;
      end
      ST_EWMA_M2: begin
        op         = OP_EWMA_M2;
        state_next = ST_EWMA_A2;
      end
      ST_EWMA_A2: begin
        op         = OP_EWMA_A2;
        state_next = ST_AVG_WR;
      end
      ST_AVG_WR: begin
        op         = OP_AVG_WR;
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        op = OP_CLASSIFY;
        if (stat.region == REGION_BETWEEN) state_next = ST_PB_MUL;
        else                               state_next = ST_FINISH;
      end
      ST_PB_MUL: begin
        op         = OP_PB_MUL;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        op         = OP_DIV_INIT;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV;
        if (stat.div_last) state_next = ST_CP_MUL;
      end
      ST_CP_MUL: begin
        op         = OP_CP_MUL;
        state_next = ST_CP_CHK;
      end
      ST_CP_CHK: begin
        op = OP_CP_CHK;
        if (stat.cp_final) state_next = ST_FINISH;
        else               state_next = ST_RP_MUL;
      end
      ST_RP_MUL: begin
        op         = OP_RP_MUL;
        state_next = ST_RP_CHK;
      end
      ST_RP_CHK: begin
        op         = OP_RP_CHK;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (slot_free) begin
          op             = OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state == ST_DISPATCH)
  `ASSERT_NEXT(a_finish_presents, state == ST_FINISH && slot_free,
               out_valid && state == ST_IDLE)
  `ASSERT_SAME(a_pow_mult_needs_bit, state == ST_POW_MP, !stat.exp_zero && stat.exp_bit0)

endmodule

FILE: rtl/wred_dp.sv
// ----------------------------------------------------------------------------
// wred_dp
// Datapath: configuration registers, queue state, one shared 27x17
// multiplier, accumulator, bit-serial divider and the result register.
// ----------------------------------------------------------------------------
module wred_dp #(
  parameter int QUEUE_DEPTH      = 1024,
  parameter int MAX_IDLE_SECONDS = 255
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wred_pkg::dp_op_t                      op,
  output wred_pkg::dp_status_t                  stat,
  input  logic                                  cfg_we,
  input  logic [wred_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wred_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  in_kind,
  input  logic                                  in_priority,
  input  logic [wred_pkg::TIME_W-1:0]           in_now,
  input  logic [wred_pkg::PCT_W-1:0]            in_rpct,
  output logic                                  out_dropped,
  output logic [wred_pkg::DEC_W-1:0]            out_decision,
  output logic [wred_pkg::QLEN_W-1:0]           out_qlen,
  output logic [wred_pkg::AVG_W-1:0]            out_avg
);
  import wred_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXP_W = $clog2(MAX_IDLE_SECONDS + 1);
  localparam logic [OCC_W-1:0]  OCC_FULL = OCC_W'(QUEUE_DEPTH);
  localparam logic [EXP_W-1:0]  EXP_CAP  = EXP_W'(MAX_IDLE_SECONDS);
  localparam logic [TIME_W-1:0] TIME_CAP = TIME_W'(MAX_IDLE_SECONDS);

  // configuration
  logic [THR_W-1:0] min_thr [2];
  logic [THR_W-1:0] max_thr [2];
  logic [Q16_W-1:0] weight;
  logic [Q16_W-1:0] max_prob;

  // queue state
  logic [OCC_W-1:0]        occ;
  logic [AVG_W-1:0]        avg;
  logic [TIME_W-1:0]       idle_since;
  logic signed [CNT_W-1:0] cnt;

  // item registers
  logic               kind;
  logic               prio;
  logic [TIME_W-1:0]  now;
  logic [PCT_W-1:0]   rpct;
  logic [DEC_W-1:0]   dec;

  // arithmetic
  logic [FAC_W-1:0]   pw;
  logic [FAC_W-1:0]   base;
  logic [EXP_W-1:0]   expo;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc;
  logic [THR_W-1:0]   rem;
  logic [Q16_W-1:0]   quo;
  logic [3:0]         dcnt;

  logic [FAC_W-1:0]   keep;
  logic [AVG_W-1:0]   lo, hi, diff;
  logic [THR_W-1:0]   span;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_next;
  logic [PROD_W-1:0]  prod_rnd;
  logic [ACC_W-1:0]   acc_rnd;
  logic [TIME_W-1:0]  elapsed;
  logic [THR_W:0]     trial;
  logic               trial_ge;
  logic [23:0]        pb_scaled;
  logic               accept;
  logic [31:0]        occ_ext;

  assign keep    = ONE_Q16 - {1'b0, weight};
  assign lo      = {min_thr[prio], 16'd0};
  assign hi      = {max_thr[prio], 16'd0};
  assign diff    = avg - lo;
  assign span    = max_thr[prio] - min_thr[prio];
  assign elapsed = now - idle_since;
  assign prod_rnd = prod + PROD_W'(32768);
  assign acc_rnd  = acc + ROUND_HALF;
  assign trial    = {rem, quo[Q16_W-1]};
  assign trial_ge = (trial >= {1'b0, span});
  assign pb_scaled = 24'(quo) * 24'(PCT_SCALE);
  assign accept    = (dec == DEC_BELOW_MIN) || (dec == DEC_RAND_KEEP);
  assign occ_ext   = 32'(occ);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_POW_MP:    begin mul_a = MUL_A_W'(pw);     mul_b = base;            end
      OP_POW_MB:    begin mul_a = MUL_A_W'(base);   mul_b = base;            end
      OP_DECAY_MUL: begin mul_a = avg;              mul_b = pw;              end
      OP_EWMA_M1:   begin mul_a = avg;              mul_b = keep;            end
      OP_EWMA_M2:   begin mul_a = MUL_A_W'(weight); mul_b = MUL_B_W'(occ);   end
      OP_PB_MUL:    begin mul_a = diff;             mul_b = MUL_B_W'(max_prob); end
      OP_CP_MUL:    begin mul_a = MUL_A_W'(cnt[5:0]); mul_b = MUL_B_W'(quo); end
      OP_RP_MUL:    begin mul_a = MUL_A_W'(base);   mul_b = MUL_B_W'(rpct);  end
      default:      begin mul_a = '0;               mul_b = '0;              end
    endcase
  end

  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    stat.in_drain = kind;
    stat.occ_zero = (occ == '0);
    stat.exp_zero = (expo == '0);
    stat.exp_bit0 = expo[0];
    stat.div_last = (dcnt == 4'd0);
    stat.cp_final = (cnt >= COUNT_LIMIT) || (prod[PROD_W-1:16] != '0);
    priority if (lo <= avg && avg < hi) stat.region = REGION_BETWEEN;
    else if (hi <= avg)                 stat.region = REGION_ABOVE;
    else                                stat.region = REGION_BELOW;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_thr[0] <= 11'd5;
      max_thr[0] <= 11'd17;
      min_thr[1] <= 11'd8;
      max_thr[1] <= 11'd22;
      weight     <= 16'd131;
      max_prob   <= 16'd1311;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_0:    min_thr[0] <= cfg_data[THR_W-1:0];
        CFG_MAX_0:    max_thr[0] <= cfg_data[THR_W-1:0];
        CFG_MIN_1:    min_thr[1] <= cfg_data[THR_W-1:0];
        CFG_MAX_1:    max_thr[1] <= cfg_data[THR_W-1:0];
        CFG_WEIGHT:   weight     <= cfg_data;
        CFG_MAX_PROB: max_prob   <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      avg        <= '0;
      idle_since <= '0;
      cnt        <= -7'sd1;
    end else begin
      unique case (op)
        OP_POW_INIT: idle_since <= now;
        OP_AVG_WR: begin
          if (acc_rnd[ACC_W-1:16] > (ACC_W-16)'(AVG_MAX)) avg <= AVG_MAX;
          else                                             avg <= acc_rnd[AVG_W+15:16];
        end
        OP_CLASSIFY: begin
          if (stat.region == REGION_BETWEEN) cnt <= cnt + 7'sd1;
        end
        OP_FINISH: begin
          if (kind) begin
            occ <= '0;
          end else if (accept && occ != OCC_FULL) begin
            occ <= occ + 1'b1;
            cnt <= -7'sd1;
          end else begin
            cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // item and arithmetic registers
  always_ff @(posedge clk) begin
    prod <= prod_next;
    unique case (op)
      OP_LOAD: begin
        kind <= in_kind;
        prio <= in_priority;
        now  <= in_now;
        rpct <= in_rpct;
        dec  <= in_kind ? DEC_DRAINED : DEC_BELOW_MIN;
      end
      OP_POW_INIT: begin
        expo <= (elapsed > TIME_CAP) ? EXP_CAP : EXP_W'(elapsed);
        pw   <= ONE_Q16;
        base <= keep;
      end
      OP_POW_UP:  pw <= prod_rnd[32:16];
      OP_POW_UB: begin
        base <= prod_rnd[32:16];
        expo <= expo >> 1;
      end
      OP_ACC_LOAD: acc <= ACC_W'(prod);
      OP_EWMA_A2:  acc <= acc + ACC_W'({prod, 16'd0});
      OP_CLASSIFY: begin
        if (stat.region == REGION_ABOVE) dec <= DEC_ABOVE_MAX;
        else                             dec <= DEC_BELOW_MIN;
      end
      OP_DIV_INIT: begin
        // quotient fits 16 bits since (avg-lo) < (hi-lo)
        rem  <= prod[42:32];
        quo  <= prod[31:16];
        dcnt <= 4'(DIV_STEPS - 1);
      end
      OP_DIV: begin
        rem  <= trial_ge ? THR_W'(trial - {1'b0, span}) : trial[THR_W-1:0];
        quo  <= {quo[Q16_W-2:0], trial_ge};
        dcnt <= dcnt - 4'd1;
      end
      OP_CP_CHK: begin
        priority if (cnt >= COUNT_LIMIT)      dec <= DEC_COUNT_DROP;
        else if (prod[PROD_W-1:16] != '0)     dec <= DEC_RAND_DROP;
        base <= ONE_Q16 - prod[FAC_W-1:0];
      end
      OP_RP_CHK: begin
        if (prod <= PROD_W'(pb_scaled)) dec <= DEC_RAND_DROP;
        else                            dec <= DEC_RAND_KEEP;
      end
      OP_FINISH: begin
        out_avg <= avg;
        if (kind) begin
          out_dropped  <= 1'b0;
          out_decision <= DEC_DRAINED;
          out_qlen     <= '0;
        end else if (accept && occ != OCC_FULL) begin
          out_dropped  <= 1'b0;
          out_decision <= dec;
          out_qlen     <= 11'(occ_ext + 32'd1);
        end else begin
          out_dropped  <= 1'b1;
          out_decision <= accept ? DEC_ABOVE_MAX : dec;
          out_qlen     <= occ_ext[QLEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/wred_drop_decision_unit.sv
// ----------------------------------------------------------------------------
// wred_drop_decision_unit
// Weighted RED admission for one packet queue: idle decay or EWMA of the
// average, threshold compare and random drop decision per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tdata now,rpct; tuser kind,priority
//  m_*      out        m_tvalid/m_tready  tdata qlen,avg; tuser dropped,decision
//  cfg_*    in         cfg_valid/cfg_ready register index and data
//
// A drain goes straight to the result. An arrival runs the EWMA path, or idle
// decay by square-and-multiply over the bits of the capped idle time, then the
// threshold compare; between thresholds the drop probability is formed by the
// shared multiplier and the 16-step divider, and a random compare follows unless
// the count limit or a certain drop decides first. One item is in work at a time;
// the next is taken while a result waits. Reset is synchronous; the result holds
// in the output register while m_tready is low. Configuration is always ready.
// ----------------------------------------------------------------------------
module wred_drop_decision_unit #(
  parameter int QUEUE_DEPTH      = 1024,
  parameter int MAX_IDLE_SECONDS = 255
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [39:0]                          s_tdata,  // now_seconds, random_pct
  input  logic [1:0]                           s_tuser,  // kind, priority_req
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [39:0]                          m_tdata,  // queue_length, avg_length
  output logic [3:0]                           m_tuser,  // dropped, decision
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wred_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wred_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import wred_pkg::*;

  dp_op_t           op;
  dp_status_t       stat;
  logic             out_dropped;
  logic [DEC_W-1:0] out_decision;
  logic [QLEN_W-1:0] out_qlen;
  logic [AVG_W-1:0] out_avg;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, out_avg, out_qlen};
  assign m_tuser   = {out_decision, out_dropped};

  wred_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .op        (op),
    .stat      (stat)
  );

  wred_dp #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .MAX_IDLE_SECONDS (MAX_IDLE_SECONDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_kind      (s_tuser[0]),
    .in_priority  (s_tuser[1]),
    .in_now       (s_tdata[31:0]),
    .in_rpct      (s_tdata[38:32]),
    .out_dropped  (out_dropped),
    .out_decision (out_decision),
    .out_qlen     (out_qlen),
    .out_avg      (out_avg)
  );

endmodule
